// ===== sv/pfs_pkg.sv =====
// Shared types and constants for the packed 12-bit field store.
// Used by pfs_ctrl, pfs_datapath and packed_12bit_field_store; no dependencies.
package pfs_pkg;

  localparam int unsigned DEFAULT_ENTRY_COUNT = 1024;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned BADDR_W  = 11;
  localparam int unsigned VALUE_W  = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 24;
  localparam int unsigned LANES    = 3;
  localparam int unsigned LANE_W   = 2;
  // Wide group index before it is cut to the memory depth.
  localparam int unsigned GRP_WIDE_W = 20;
  // floor(a/3) = (a * 2731) >> 13 for every 11-bit a.
  localparam logic [11:0] RECIP3   = 12'd2731;
  localparam int unsigned RECIP3_SH = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_RD_ENTRY = 2'd0,
    CMD_WR_ENTRY = 2'd1,
    CMD_RD_BYTE  = 2'd2,
    CMD_WR_BYTE  = 2'd3
  } cmd_e;

  // Controller -> datapath.
  typedef struct packed {
    logic capture;   // latch request fields
    logic mem_rd;    // read the group from all lanes
    logic mem_wr;    // commit a write command
    logic load_out;  // load the result register
  } ctrl_cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic is_read;
  } dp_status_t;

endpackage

// ===== sv/pfs_ctrl.sv =====
// Controller for the packed 12-bit field store: sequences one beat through
// fetch and execute, and owns the result valid flag. Depends on pfs_pkg.
module pfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pfs_pkg::dp_status_t status_i,
  output pfs_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.is_read) begin
          // hold the read data until the result slot frees up
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            out_valid_d    = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.mem_wr = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/pfs_datapath.sv =====
// Datapath for the packed 12-bit field store: request registers, address
// split, three byte-lane memories, entry merge and result register. Uses pfs_pkg.
module pfs_datapath #(
  parameter int unsigned ENTRY_COUNT = pfs_pkg::DEFAULT_ENTRY_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic [pfs_pkg::CMD_W-1:0]     command_i,
  input  logic [pfs_pkg::INDEX_W-1:0]   entry_index_i,
  input  logic [pfs_pkg::BADDR_W-1:0]   byte_address_i,
  input  logic [pfs_pkg::VALUE_W-1:0]   write_value_i,
  output logic [pfs_pkg::VALUE_W-1:0]   read_data_o,
  input  pfs_pkg::ctrl_cmd_t            cmd_i,
  output pfs_pkg::dp_status_t           status_o
);

  localparam int unsigned Groups     = (ENTRY_COUNT + 1) / 2;
  localparam int unsigned StoreBytes = 3 * Groups;
  localparam int unsigned GroupW     = (Groups > 1) ? $clog2(Groups) : 1;

  localparam int unsigned ProdW = pfs_pkg::BADDR_W + 12;

  // ---- layout register ----
  logic big_endian_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      big_endian_q <= cfg_wdata_i;
    end
  end

  // ---- address split: group and lane ----
  logic [ProdW-1:0]                  prod;
  logic [pfs_pkg::INDEX_W-1:0]       byte_grp;
  logic [pfs_pkg::BADDR_W-1:0]       grp_times3;
  logic [pfs_pkg::LANE_W-1:0]        byte_lane;
  logic [pfs_pkg::GRP_WIDE_W-1:0]    grp_wide;
  logic                              entry_cmd;
  logic                              req_ok;

  assign prod       = ProdW'(byte_address_i) * ProdW'(pfs_pkg::RECIP3);
  assign byte_grp   = prod[pfs_pkg::RECIP3_SH +: pfs_pkg::INDEX_W];
  assign grp_times3 = pfs_pkg::BADDR_W'({byte_grp, 1'b0}) + pfs_pkg::BADDR_W'(byte_grp);
  assign byte_lane  = pfs_pkg::LANE_W'(byte_address_i - grp_times3);

  assign entry_cmd = (pfs_pkg::cmd_e'(command_i) == pfs_pkg::CMD_RD_ENTRY) ||
                     (pfs_pkg::cmd_e'(command_i) == pfs_pkg::CMD_WR_ENTRY);

  always_comb begin
    if (entry_cmd) begin
      grp_wide = pfs_pkg::GRP_WIDE_W'(entry_index_i[pfs_pkg::INDEX_W-1:1]);
      req_ok   = 32'(entry_index_i) < 32'(ENTRY_COUNT);
    end else begin
      grp_wide = pfs_pkg::GRP_WIDE_W'(byte_grp);
      req_ok   = 32'(byte_address_i) < 32'(StoreBytes);
    end
  end

  // ---- request registers ----
  pfs_pkg::cmd_e                req_cmd_q;
  logic [GroupW-1:0]            req_grp_q;
  logic [pfs_pkg::LANE_W-1:0]   req_lane_q;
  logic                         req_odd_q;
  logic                         req_ok_q;
  logic [pfs_pkg::VALUE_W-1:0]  req_val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_cmd_q  <= pfs_pkg::cmd_e'(command_i);
      req_grp_q  <= grp_wide[GroupW-1:0];
      req_lane_q <= byte_lane;
      req_odd_q  <= entry_index_i[0];
      req_ok_q   <= req_ok;
      req_val_q  <= write_value_i;
    end
  end

  assign status_o.is_read = (req_cmd_q == pfs_pkg::CMD_RD_ENTRY) ||
                            (req_cmd_q == pfs_pkg::CMD_RD_BYTE);

  // ---- entry merge ----
  logic [pfs_pkg::BYTE_W-1:0]  rd_q   [pfs_pkg::LANES];
  logic [pfs_pkg::BYTE_W-1:0]  wr_byte[pfs_pkg::LANES];
  logic [pfs_pkg::LANES-1:0]   wr_en;
  logic [pfs_pkg::WORD_W-1:0]  word, new_word;
  logic                        hi_slot;
  logic [pfs_pkg::VALUE_W-1:0] entry_val;
  logic [pfs_pkg::BYTE_W-1:0]  lane_byte;
  logic [pfs_pkg::VALUE_W-1:0] result;

  // entry sits in word bits 23..12 for an odd LE entry or an even BE entry
  assign hi_slot = req_odd_q ^ big_endian_q;
  assign word    = big_endian_q ? {rd_q[0], rd_q[1], rd_q[2]}
                                : {rd_q[2], rd_q[1], rd_q[0]};
  assign entry_val = hi_slot ? word[23:12] : word[11:0];
  assign new_word  = hi_slot ? {req_val_q, word[11:0]} : {word[23:12], req_val_q};

  always_comb begin
    unique case (req_lane_q)
      2'd0:    lane_byte = rd_q[0];
      2'd1:    lane_byte = rd_q[1];
      2'd2:    lane_byte = rd_q[2];
      default: lane_byte = '0;
    endcase
  end

  always_comb begin
    wr_en = '0;
    if (big_endian_q) begin
      wr_byte[0] = new_word[23:16];
      wr_byte[2] = new_word[7:0];
    end else begin
      wr_byte[0] = new_word[7:0];
      wr_byte[2] = new_word[23:16];
    end
    wr_byte[1] = new_word[15:8];
    if (cmd_i.mem_wr && req_ok_q) begin
      if (req_cmd_q == pfs_pkg::CMD_WR_ENTRY) begin
        wr_en = '1;
      end else if (req_cmd_q == pfs_pkg::CMD_WR_BYTE) begin
        for (int l = 0; l < pfs_pkg::LANES; l++) begin
          wr_byte[l] = req_val_q[pfs_pkg::BYTE_W-1:0];
          wr_en[l]   = (req_lane_q == pfs_pkg::LANE_W'(l));
        end
      end
    end
  end

  // ---- byte-lane memories, one byte of each group per lane ----
  for (genvar g = 0; g < pfs_pkg::LANES; g++) begin : g_lane
    logic [pfs_pkg::BYTE_W-1:0] mem [Groups];

    always_ff @(posedge clk_i) begin
      if (wr_en[g]) begin
        mem[req_grp_q] <= wr_byte[g];
      end
      if (cmd_i.mem_rd) begin
        rd_q[g] <= mem[req_grp_q];
      end
    end
  end

  // ---- result register ----
  always_comb begin
    if (!req_ok_q) begin
      result = '0;
    end else if (req_cmd_q == pfs_pkg::CMD_RD_ENTRY) begin
      result = entry_val;
    end else begin
      result = pfs_pkg::VALUE_W'(lane_byte);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      read_data_o <= result;
    end
  end

endmodule

// ===== sv/packed_12bit_field_store.sv =====
// Top level of the packed 12-bit field store.
// Joins pfs_ctrl and pfs_datapath; uses pfs_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one command beat:
//    read entry, write entry, read byte or write byte, with entry_index_i,
//    byte_address_i and write_value_i. Fields a command does not use are
//    ignored.
//  - Output channel (out_valid_o / out_ready_i) carries one read_data_o beat
//    for each read; writes produce no beat. Out-of-range indexes and
//    addresses read as zero and ignore writes.
//  - cfg_we_i / cfg_wdata_i set the layout bit (0 little-endian, 1
//    big-endian); write it only while the block is idle.
//  - Each beat passes through accept, group fetch from the three byte-lane
//    memories, then merge/write-back or result load. A read result appears
//    in the cycle after the execute step. One beat is in flight at a time:
//    the controller accepts a new beat only in its idle state.
//  - A new beat is accepted while an earlier result still waits in the
//    output register; a read that finishes while that register is full
//    waits in its execute step until the receiver takes the old result.
//  - Reset clears the controller, the result valid flag and the layout bit
//    (little-endian). Store contents are undefined until written.
module packed_12bit_field_store #(
  parameter int unsigned ENTRY_COUNT = pfs_pkg::DEFAULT_ENTRY_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pfs_pkg::CMD_W-1:0]   command_i,
  input  logic [pfs_pkg::INDEX_W-1:0] entry_index_i,
  input  logic [pfs_pkg::BADDR_W-1:0] byte_address_i,
  input  logic [pfs_pkg::VALUE_W-1:0] write_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pfs_pkg::VALUE_W-1:0] read_data_o
);

  pfs_pkg::ctrl_cmd_t  ctrl_cmd;
  pfs_pkg::dp_status_t dp_status;

  pfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  pfs_datapath #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .byte_address_i (byte_address_i),
    .write_value_i  (write_value_i),
    .read_data_o    (read_data_o),
    .cmd_i          (ctrl_cmd),
    .status_o       (dp_status)
  );

endmodule
